/* src/acb_pkg.sv */
// shared types, widths and register codes for the affine coordinate hash bin
`default_nettype none

package acb_pkg;

    localparam int MAX_GRID_SIDE = 64;

    localparam int IN_W      = 16;
    localparam int DIFF_W    = IN_W + 1;
    localparam int PROD_W    = DIFF_W + IN_W;
    localparam int DET_W     = 2 * IN_W + 1;
    localparam int NUM_W     = PROD_W + 1;
    localparam int FRAC_BITS = 8;
    localparam int QBITS     = 18;
    localparam int COORD_W   = QBITS;
    localparam int OUT_W     = 16;
    localparam int N_W       = NUM_W + FRAC_BITS;
    localparam int D_W       = DET_W;
    localparam int CMP_W     = D_W + QBITS;

    localparam int GRID_CFG_W = 7;
    localparam int SIDE_W     = $clog2(MAX_GRID_SIDE + 1);
    localparam int IDX_W      = (MAX_GRID_SIDE > 1) ? $clog2(MAX_GRID_SIDE) : 1;
    localparam int RANGE_W    = 16;
    localparam int MW         = RANGE_W + SIDE_W;
    localparam int GCMP_W     = MW + IDX_W;
    localparam int BIN_W      = 2 * SIDE_W + 1;
    localparam int BIN_OUT_W  = 12;
    localparam int BIN_MAX    = 4095;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd5;

    typedef struct packed {
        logic signed [DET_W-1:0] det;
        logic signed [NUM_W-1:0] nu;
        logic signed [NUM_W-1:0] nv;
    } acb_item_t;

    typedef struct packed {
        logic signed [RANGE_W-1:0] min_x;
        logic signed [RANGE_W-1:0] max_x;
        logic signed [RANGE_W-1:0] min_y;
        logic signed [RANGE_W-1:0] max_y;
        logic [GRID_CFG_W-1:0]     grid_w;
        logic [GRID_CFG_W-1:0]     grid_h;
    } acb_cfg_t;

endpackage

`default_nettype wire

/* src/acb_front.sv */
// front end: origin subtraction, cross products and cramer numerators
`default_nettype none

module acb_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic signed [acb_pkg::IN_W-1:0]   point_x,
    input  wire logic signed [acb_pkg::IN_W-1:0]   point_y,
    input  wire logic signed [acb_pkg::IN_W-1:0]   origin_x,
    input  wire logic signed [acb_pkg::IN_W-1:0]   origin_y,
    input  wire logic signed [acb_pkg::IN_W-1:0]   first_vec_x,
    input  wire logic signed [acb_pkg::IN_W-1:0]   first_vec_y,
    input  wire logic signed [acb_pkg::IN_W-1:0]   second_vec_x,
    input  wire logic signed [acb_pkg::IN_W-1:0]   second_vec_y,
    input  wire logic                              fifo_full,
    output logic                                   push,
    output acb_pkg::acb_item_t                     push_item
);

    logic f_en;

    logic s1_valid_reg;
    logic signed [acb_pkg::DIFF_W-1:0] dx_reg, dy_reg;
    logic signed [acb_pkg::IN_W-1:0]   ax_reg, ay_reg, bx_reg, by_reg;

    logic s2_valid_reg;
    logic signed [acb_pkg::PROD_W-1:0] axby_reg, bxay_reg;
    logic signed [acb_pkg::PROD_W-1:0] dxby_reg, dybx_reg, dyax_reg, dxay_reg;

    assign f_en     = !(s2_valid_reg && fifo_full);
    assign in_stall = !f_en;
    assign push     = s2_valid_reg && !fifo_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (f_en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_en)
        begin
            dx_reg <= acb_pkg::DIFF_W'(point_x) - acb_pkg::DIFF_W'(origin_x);
            dy_reg <= acb_pkg::DIFF_W'(point_y) - acb_pkg::DIFF_W'(origin_y);
            ax_reg <= first_vec_x;
            ay_reg <= first_vec_y;
            bx_reg <= second_vec_x;
            by_reg <= second_vec_y;
            axby_reg <= acb_pkg::PROD_W'(ax_reg) * acb_pkg::PROD_W'(by_reg);
            bxay_reg <= acb_pkg::PROD_W'(bx_reg) * acb_pkg::PROD_W'(ay_reg);
            dxby_reg <= acb_pkg::PROD_W'(dx_reg) * acb_pkg::PROD_W'(by_reg);
            dybx_reg <= acb_pkg::PROD_W'(dy_reg) * acb_pkg::PROD_W'(bx_reg);
            dyax_reg <= acb_pkg::PROD_W'(dy_reg) * acb_pkg::PROD_W'(ax_reg);
            dxay_reg <= acb_pkg::PROD_W'(dx_reg) * acb_pkg::PROD_W'(ay_reg);
        end
    end

    always_comb
    begin
        push_item.det = acb_pkg::DET_W'(axby_reg) - acb_pkg::DET_W'(bxay_reg);
        push_item.nu  = acb_pkg::NUM_W'(dxby_reg) - acb_pkg::NUM_W'(dybx_reg);
        push_item.nv  = acb_pkg::NUM_W'(dyax_reg) - acb_pkg::NUM_W'(dxay_reg);
    end

endmodule

`default_nettype wire

/* src/acb_fifo.sv */
// short queue between front end and division back end
`default_nettype none

module acb_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire acb_pkg::acb_item_t push_item,
    output logic                    full,
    input  wire logic               pop,
    output acb_pkg::acb_item_t      head,
    output logic                    empty
);

    acb_pkg::acb_item_t mem [acb_pkg::FIFO_DEPTH];

    logic [acb_pkg::FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [acb_pkg::FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [acb_pkg::FIFO_AW:0]   count_reg, count_next;

    assign full  = (count_reg == (acb_pkg::FIFO_AW + 1)'(acb_pkg::FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (acb_pkg::FIFO_AW + 1)'(acb_pkg::FIFO_DEPTH))
        else $error("queue count above depth");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

/* src/acb_back.sv */
// back end: pipelined division, grid quantization and bin index
`default_nettype none

module acb_back (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire acb_pkg::acb_cfg_t                   cfg,
    input  wire acb_pkg::acb_item_t                  head,
    input  wire logic                                fifo_empty,
    output logic                                     pop,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [acb_pkg::BIN_OUT_W-1:0]            bin_index,
    output logic                                     bin_valid,
    output logic                                     degenerate,
    output logic signed [acb_pkg::OUT_W-1:0]         coord_x,
    output logic signed [acb_pkg::OUT_W-1:0]         coord_y
);

    typedef struct packed {
        logic [acb_pkg::N_W-1:0]   rem;
        logic [acb_pkg::QBITS-1:0] quo;
        logic                      neg;
        logic                      ovf;
    } acb_div_t;

    typedef struct packed {
        logic [acb_pkg::MW-1:0]    rem;
        logic [acb_pkg::IDX_W-1:0] quo;
        logic                      ok;
    } acb_grid_t;

    function automatic acb_div_t div_step(acb_div_t s, logic [acb_pkg::D_W-1:0] d,
                                          int bit_pos);
        acb_div_t r;
        logic [acb_pkg::CMP_W-1:0] trial;
        logic [acb_pkg::CMP_W-1:0] rem_x;
        r     = s;
        trial = acb_pkg::CMP_W'(d) << bit_pos;
        rem_x = acb_pkg::CMP_W'(s.rem);
        if (rem_x >= trial)
        begin
            r.rem          = acb_pkg::N_W'(rem_x - trial);
            r.quo[bit_pos] = 1'b1;
        end
        return r;
    endfunction

    function automatic acb_grid_t grid_step(acb_grid_t s, logic [acb_pkg::RANGE_W-1:0] d,
                                            int bit_pos);
        acb_grid_t r;
        logic [acb_pkg::GCMP_W-1:0] trial;
        logic [acb_pkg::GCMP_W-1:0] rem_x;
        r     = s;
        trial = acb_pkg::GCMP_W'(d) << bit_pos;
        rem_x = acb_pkg::GCMP_W'(s.rem);
        if (rem_x >= trial)
        begin
            r.rem          = acb_pkg::MW'(rem_x - trial);
            r.quo[bit_pos] = 1'b1;
        end
        return r;
    endfunction

    // floor of the signed quotient, clamped to the coordinate width; zero for a zero divisor
    function automatic logic signed [acb_pkg::COORD_W-1:0] to_coord(acb_div_t s, logic dz);
        logic signed [acb_pkg::COORD_W+1:0] q;
        logic signed [acb_pkg::COORD_W+1:0] hi;
        logic signed [acb_pkg::COORD_W+1:0] lo;
        hi = (acb_pkg::COORD_W + 2)'((1 << (acb_pkg::COORD_W - 1)) - 1);
        lo = -(acb_pkg::COORD_W + 2)'(1 << (acb_pkg::COORD_W - 1));
        q  = $signed({2'b00, s.quo});
        if (s.neg)
        begin
            q = (s.rem != '0) ? -q - (acb_pkg::COORD_W + 2)'(1) : -q;
        end
        if (dz)
        begin
            q = '0;
        end
        else if (s.ovf)
        begin
            q = s.neg ? lo : hi;
        end
        else if (q > hi)
        begin
            q = hi;
        end
        else if (q < lo)
        begin
            q = lo;
        end
        return acb_pkg::COORD_W'(q);
    endfunction

    function automatic logic signed [acb_pkg::OUT_W-1:0] sat_out(
        logic signed [acb_pkg::COORD_W-1:0] c);
        logic signed [acb_pkg::COORD_W-1:0] hi;
        logic signed [acb_pkg::COORD_W-1:0] lo;
        hi = acb_pkg::COORD_W'((1 << (acb_pkg::OUT_W - 1)) - 1);
        lo = -acb_pkg::COORD_W'(1 << (acb_pkg::OUT_W - 1));
        if (c > hi)
        begin
            return acb_pkg::OUT_W'(hi);
        end
        else if (c < lo)
        begin
            return acb_pkg::OUT_W'(lo);
        end
        return acb_pkg::OUT_W'(c);
    endfunction

    function automatic logic [acb_pkg::SIDE_W-1:0] eff_side(
        logic [acb_pkg::GRID_CFG_W-1:0] g);
        if (int'(g) > acb_pkg::MAX_GRID_SIDE)
        begin
            return acb_pkg::SIDE_W'(acb_pkg::MAX_GRID_SIDE);
        end
        return acb_pkg::SIDE_W'(g);
    endfunction

    logic adv;
    logic [acb_pkg::SIDE_W-1:0]  side_w, side_h;
    logic [acb_pkg::RANGE_W-1:0] span_x, span_y;
    logic signed [acb_pkg::RANGE_W:0] span_xs, span_ys;
    logic empty_rng;

    assign adv    = !out_valid || !out_stall;
    assign pop    = adv && !fifo_empty;
    assign side_w = eff_side(cfg.grid_w);
    assign side_h = eff_side(cfg.grid_h);
    assign span_xs = (acb_pkg::RANGE_W + 1)'(cfg.max_x) - (acb_pkg::RANGE_W + 1)'(cfg.min_x);
    assign span_ys = (acb_pkg::RANGE_W + 1)'(cfg.max_y) - (acb_pkg::RANGE_W + 1)'(cfg.min_y);
    assign span_x = span_xs[acb_pkg::RANGE_W-1:0];
    assign span_y = span_ys[acb_pkg::RANGE_W-1:0];
    assign empty_rng = (cfg.max_x <= cfg.min_x) || (cfg.max_y <= cfg.min_y);

    // division stages
    logic                      dvld_reg [acb_pkg::QBITS+1];
    logic [acb_pkg::D_W-1:0]   dd_reg   [acb_pkg::QBITS+1];
    logic                      dz_reg   [acb_pkg::QBITS+1];
    acb_div_t                  du_reg   [acb_pkg::QBITS+1];
    acb_div_t                  dv_reg   [acb_pkg::QBITS+1];

    acb_div_t                  du_next, dv_next;
    logic [acb_pkg::D_W-1:0]   dd_next;
    logic [acb_pkg::NUM_W-1:0] mag_u, mag_v;

    always_comb
    begin
        dd_next = head.det[acb_pkg::DET_W-1] ? acb_pkg::D_W'(-head.det)
                                             : acb_pkg::D_W'(head.det);
        mag_u   = head.nu[acb_pkg::NUM_W-1] ? acb_pkg::NUM_W'(-head.nu)
                                            : acb_pkg::NUM_W'(head.nu);
        mag_v   = head.nv[acb_pkg::NUM_W-1] ? acb_pkg::NUM_W'(-head.nv)
                                            : acb_pkg::NUM_W'(head.nv);
        du_next.rem = {mag_u, {acb_pkg::FRAC_BITS{1'b0}}};
        du_next.quo = '0;
        du_next.neg = head.nu[acb_pkg::NUM_W-1] ^ head.det[acb_pkg::DET_W-1];
        du_next.ovf = acb_pkg::CMP_W'(du_next.rem) >= (acb_pkg::CMP_W'(dd_next) << acb_pkg::QBITS);
        dv_next.rem = {mag_v, {acb_pkg::FRAC_BITS{1'b0}}};
        dv_next.quo = '0;
        dv_next.neg = head.nv[acb_pkg::NUM_W-1] ^ head.det[acb_pkg::DET_W-1];
        dv_next.ovf = acb_pkg::CMP_W'(dv_next.rem) >= (acb_pkg::CMP_W'(dd_next) << acb_pkg::QBITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            dvld_reg[0] <= !fifo_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dd_reg[0] <= dd_next;
            dz_reg[0] <= (head.det == '0);
            du_reg[0] <= du_next;
            dv_reg[0] <= dv_next;
        end
    end

    for (genvar gk = 1; gk <= acb_pkg::QBITS; gk++)
    begin : g_div
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dvld_reg[gk] <= 1'b0;
            end
            else if (adv)
            begin
                dvld_reg[gk] <= dvld_reg[gk-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dd_reg[gk] <= dd_reg[gk-1];
                dz_reg[gk] <= dz_reg[gk-1];
                du_reg[gk] <= div_step(du_reg[gk-1], dd_reg[gk-1], acb_pkg::QBITS - gk);
                dv_reg[gk] <= div_step(dv_reg[gk-1], dd_reg[gk-1], acb_pkg::QBITS - gk);
            end
        end
    end

    // sign and floor fix-up
    logic                               cvld_reg;
    logic                               cdz_reg;
    logic signed [acb_pkg::COORD_W-1:0] cu_reg, cv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cvld_reg <= 1'b0;
        end
        else if (adv)
        begin
            cvld_reg <= dvld_reg[acb_pkg::QBITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cdz_reg <= dz_reg[acb_pkg::QBITS];
            cu_reg  <= to_coord(du_reg[acb_pkg::QBITS], dz_reg[acb_pkg::QBITS]);
            cv_reg  <= to_coord(dv_reg[acb_pkg::QBITS], dz_reg[acb_pkg::QBITS]);
        end
    end

    // grid quantization stages
    logic                            gvld_reg [acb_pkg::IDX_W+1];
    logic                            gdz_reg  [acb_pkg::IDX_W+1];
    logic signed [acb_pkg::OUT_W-1:0] gcx_reg [acb_pkg::IDX_W+1];
    logic signed [acb_pkg::OUT_W-1:0] gcy_reg [acb_pkg::IDX_W+1];
    acb_grid_t                       gx_reg   [acb_pkg::IDX_W+1];
    acb_grid_t                       gy_reg   [acb_pkg::IDX_W+1];

    acb_grid_t gx_next, gy_next;
    logic signed [acb_pkg::COORD_W:0] tx, ty;

    always_comb
    begin
        tx = (acb_pkg::COORD_W + 1)'(cu_reg) - (acb_pkg::COORD_W + 1)'(cfg.min_x);
        ty = (acb_pkg::COORD_W + 1)'(cv_reg) - (acb_pkg::COORD_W + 1)'(cfg.min_y);
        gx_next.ok  = !tx[acb_pkg::COORD_W] && (cu_reg < acb_pkg::COORD_W'(cfg.max_x))
                      && (side_w != '0);
        gy_next.ok  = !ty[acb_pkg::COORD_W] && (cv_reg < acb_pkg::COORD_W'(cfg.max_y))
                      && (side_h != '0);
        gx_next.rem = acb_pkg::MW'(tx[acb_pkg::RANGE_W-1:0]) * acb_pkg::MW'(side_w);
        gy_next.rem = acb_pkg::MW'(ty[acb_pkg::RANGE_W-1:0]) * acb_pkg::MW'(side_h);
        gx_next.quo = '0;
        gy_next.quo = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gvld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            gvld_reg[0] <= cvld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gdz_reg[0] <= cdz_reg;
            gcx_reg[0] <= sat_out(cu_reg);
            gcy_reg[0] <= sat_out(cv_reg);
            gx_reg[0]  <= gx_next;
            gy_reg[0]  <= gy_next;
        end
    end

    for (genvar gk = 1; gk <= acb_pkg::IDX_W; gk++)
    begin : g_grid
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                gvld_reg[gk] <= 1'b0;
            end
            else if (adv)
            begin
                gvld_reg[gk] <= gvld_reg[gk-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                gdz_reg[gk] <= gdz_reg[gk-1];
                gcx_reg[gk] <= gcx_reg[gk-1];
                gcy_reg[gk] <= gcy_reg[gk-1];
                gx_reg[gk]  <= grid_step(gx_reg[gk-1], span_x, acb_pkg::IDX_W - gk);
                gy_reg[gk]  <= grid_step(gy_reg[gk-1], span_y, acb_pkg::IDX_W - gk);
            end
        end
    end

    // bin index and output register
    logic [acb_pkg::BIN_W-1:0] bin_full;
    logic                      degen_next;
    logic                      ok_next;

    always_comb
    begin
        bin_full   = acb_pkg::BIN_W'(gy_reg[acb_pkg::IDX_W].quo) * acb_pkg::BIN_W'(side_w)
                   + acb_pkg::BIN_W'(gx_reg[acb_pkg::IDX_W].quo);
        degen_next = gdz_reg[acb_pkg::IDX_W] || empty_rng;
        ok_next    = !degen_next && gx_reg[acb_pkg::IDX_W].ok && gy_reg[acb_pkg::IDX_W].ok
                     && (bin_full <= acb_pkg::BIN_W'(acb_pkg::BIN_MAX));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (adv)
        begin
            out_valid <= gvld_reg[acb_pkg::IDX_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bin_index  <= ok_next ? acb_pkg::BIN_OUT_W'(bin_full) : '0;
            bin_valid  <= ok_next;
            degenerate <= degen_next;
            coord_x    <= gcx_reg[acb_pkg::IDX_W];
            coord_y    <= gcy_reg[acb_pkg::IDX_W];
        end
    end

`ifndef ASSERT_OFF
    a_bin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !bin_valid) |-> (bin_index == '0))
        else $error("bin index nonzero on invalid bin");
    a_degen_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && degenerate) |-> !bin_valid)
        else $error("degenerate item given a valid bin");
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(bin_index) && $stable(coord_x)))
        else $error("result changed while stalled");
`endif

endmodule

`default_nettype wire

/* src/affine_coords_hash_bin.sv */
// top level: config registers, front end, queue and division back end
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in      | into      | in_valid/in_stall  | point, origin, two basis vectors (Q12.4)
//  out     | out of    | out_valid/out_stall| bin_index, bin_valid, degenerate, coords
//  cfg     | into      | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  one item per cycle sustained while out_stall is low; an item passes the front registers,
//  the queue, then the back stages: load, 18 quotient bits, fix-up, grid setup, 6 grid index
//  bits and the output register (quotient length and grid bits follow the package widths)
//  the back pipeline moves as one; the output register frees it whenever taken
//  the 4-deep queue absorbs back pressure so the front end stalls only when it fills
//  reset clears valid bits, queue pointers and restores the config defaults
`default_nettype none

module affine_coords_hash_bin (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [acb_pkg::IN_W-1:0]      point_x,
    input  wire logic signed [acb_pkg::IN_W-1:0]      point_y,
    input  wire logic signed [acb_pkg::IN_W-1:0]      origin_x,
    input  wire logic signed [acb_pkg::IN_W-1:0]      origin_y,
    input  wire logic signed [acb_pkg::IN_W-1:0]      first_vec_x,
    input  wire logic signed [acb_pkg::IN_W-1:0]      first_vec_y,
    input  wire logic signed [acb_pkg::IN_W-1:0]      second_vec_x,
    input  wire logic signed [acb_pkg::IN_W-1:0]      second_vec_y,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [acb_pkg::BIN_OUT_W-1:0]             bin_index,
    output logic                                      bin_valid,
    output logic                                      degenerate,
    output logic signed [acb_pkg::OUT_W-1:0]          coord_x,
    output logic signed [acb_pkg::OUT_W-1:0]          coord_y,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [acb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [acb_pkg::CFG_DATA_W-1:0]       cfg_data
);

    acb_pkg::acb_cfg_t  cfg_reg;
    acb_pkg::acb_item_t push_item;
    acb_pkg::acb_item_t head;
    logic push, pop, fifo_full, fifo_empty;

    // config writes are always accepted and registered
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_x  <= -16'sd256;
            cfg_reg.max_x  <= 16'sd512;
            cfg_reg.min_y  <= -16'sd256;
            cfg_reg.max_y  <= 16'sd512;
            cfg_reg.grid_w <= 7'd16;
            cfg_reg.grid_h <= 7'd16;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                acb_pkg::REG_RANGE_MIN_X: cfg_reg.min_x  <= cfg_data;
                acb_pkg::REG_RANGE_MAX_X: cfg_reg.max_x  <= cfg_data;
                acb_pkg::REG_RANGE_MIN_Y: cfg_reg.min_y  <= cfg_data;
                acb_pkg::REG_RANGE_MAX_Y: cfg_reg.max_y  <= cfg_data;
                acb_pkg::REG_GRID_WIDTH:  cfg_reg.grid_w <= cfg_data[acb_pkg::GRID_CFG_W-1:0];
                acb_pkg::REG_GRID_HEIGHT: cfg_reg.grid_h <= cfg_data[acb_pkg::GRID_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // products and numerators
    acb_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .point_x      (point_x),
        .point_y      (point_y),
        .origin_x     (origin_x),
        .origin_y     (origin_y),
        .first_vec_x  (first_vec_x),
        .first_vec_y  (first_vec_y),
        .second_vec_x (second_vec_x),
        .second_vec_y (second_vec_y),
        .fifo_full    (fifo_full),
        .push         (push),
        .push_item    (push_item)
    );

    // decouples the front end from output back pressure
    acb_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (fifo_full),
        .pop       (pop),
        .head      (head),
        .empty     (fifo_empty)
    );

    // division, grid placement, result register
    acb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head       (head),
        .fifo_empty (fifo_empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .bin_index  (bin_index),
        .bin_valid  (bin_valid),
        .degenerate (degenerate),
        .coord_x    (coord_x),
        .coord_y    (coord_y)
    );

endmodule

`default_nettype wire
